[hdl/slr_pkg.sv]
`timescale 1ns / 1ps

package slr_pkg;

  localparam int COORD_BITS      = 12;
  localparam int OUT_FRAC_BITS   = 8;
  localparam int SLOPE_FRAC_BITS = 16;

  localparam int OUT_W      = COORD_BITS + OUT_FRAC_BITS;
  localparam int ACC_W      = COORD_BITS + SLOPE_FRAC_BITS;
  localparam int SLOPE_W    = SLOPE_FRAC_BITS + 2;
  localparam int QUO_W      = SLOPE_FRAC_BITS + 1;
  localparam int CNT_W      = $clog2(SLOPE_FRAC_BITS + 1);
  localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam int PC_W     = 2;
  localparam int PROG_LEN = 4;

  localparam logic [PC_W-1:0] PC_TAKE   = 2'd0;
  localparam logic [PC_W-1:0] PC_SETUP  = 2'd1;
  localparam logic [PC_W-1:0] PC_DIV    = 2'd2;
  localparam logic [PC_W-1:0] PC_FINISH = 2'd3;

  typedef enum logic [1:0] {OP_TAKE, OP_SETUP, OP_DIV, OP_FINISH} op_t;

  // jump to target when the condition holds, else fall through
  typedef enum logic [1:0] {CND_ALWAYS, CND_NO_START, CND_ZERO_LEN, CND_DIV_MORE} cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic start_taken;
    logic zero_len;
    logic div_more;
  } dp_status_t;

  localparam uword_t UPROG [PROG_LEN] = '{
    '{op: OP_TAKE,   cond: CND_NO_START, target: PC_TAKE},
    '{op: OP_SETUP,  cond: CND_ZERO_LEN, target: PC_TAKE},
    '{op: OP_DIV,    cond: CND_DIV_MORE, target: PC_DIV},
    '{op: OP_FINISH, cond: CND_ALWAYS,   target: PC_TAKE}
  };

endpackage

[hdl/slr_useq.sv]
`timescale 1ns / 1ps

module slr_useq (
  input  logic                clk,
  input  logic                rst,
  input  slr_pkg::dp_status_t status,
  output slr_pkg::uword_t     uw
);
  import slr_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            jump;

  assign uw = UPROG[pc];

  always_comb begin
    case (uw.cond)
      CND_ALWAYS:   jump = 1'b1;
      CND_NO_START: jump = !status.start_taken;
      CND_ZERO_LEN: jump = status.zero_len;
      CND_DIV_MORE: jump = status.div_more;
      default:      jump = 1'b1;
    endcase
    pc_next = jump ? uw.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_TAKE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[hdl/slr_dpath.sv]
`timescale 1ns / 1ps

module slr_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  slr_pkg::op_t                        op,
  output slr_pkg::dp_status_t                 status,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic                                s_tuser,
  input  logic [slr_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [slr_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                m_tlast
);
  import slr_pkg::*;

  localparam int RND_SH = SLOPE_FRAC_BITS - OUT_FRAC_BITS;

  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic                  line_active;
  logic                  major_is_x;
  logic                  step_backward;
  logic                  minor_neg;
  logic [COORD_BITS-1:0] current_major;
  logic [COORD_BITS-1:0] final_major;
  logic [ACC_W-1:0]      minor_accumulator;
  logic [SLOPE_W-1:0]    slope_value;
  logic [COORD_BITS-1:0] divisor;
  logic [COORD_BITS-1:0] rem;
  logic [QUO_W-1:0]      quo;
  logic [CNT_W-1:0]      cnt;

  logic                  accept;
  logic                  emit;
  logic [COORD_BITS:0]   dx, dy, dx_neg, dy_neg;
  logic [COORD_BITS-1:0] adx, ady, admaj, admin, minor_start;
  logic                  mx;
  logic [COORD_BITS:0]   rem_shift;
  logic                  rem_ge;
  logic [OUT_W-1:0]      maj_out, min_out;
  logic                  last;

  function automatic logic [OUT_W-1:0] mx_out_y(input logic         is_x,
                                                input logic [OUT_W-1:0] maj,
                                                input logic [OUT_W-1:0] mnr);
    mx_out_y = is_x ? mnr : maj;
  endfunction

  assign s_tready = (op == OP_TAKE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign emit     = accept && (s_tuser == CMD_STEP) && line_active;

  always_comb begin
    dx     = {1'b0, bx} - {1'b0, ax};
    dy     = {1'b0, by} - {1'b0, ay};
    dx_neg = (COORD_BITS + 1)'(0) - dx;
    dy_neg = (COORD_BITS + 1)'(0) - dy;
    adx    = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ady    = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    mx     = adx >= ady;
    admaj  = mx ? adx : ady;
    admin  = mx ? ady : adx;
    minor_start = mx ? ay : ax;
  end

  assign status.start_taken = accept && (s_tuser == CMD_START);
  assign status.zero_len    = (ax == bx) && (ay == by);
  assign status.div_more    = cnt != CNT_W'(1);

  // one restoring divide step per cycle
  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, divisor};

  assign maj_out = OUT_W'(current_major) << OUT_FRAC_BITS;
  assign last    = current_major == final_major;

  generate
    if (SLOPE_FRAC_BITS > OUT_FRAC_BITS) begin : g_round
      logic [ACC_W:0] rsum;
      logic [OUT_W:0] rq;
      assign rsum    = {1'b0, minor_accumulator} + ((ACC_W + 1)'(1) << (RND_SH - 1));
      assign rq      = rsum[ACC_W:RND_SH];
      assign min_out = rq[OUT_W] ? {OUT_W{1'b1}} : rq[OUT_W-1:0];
    end else begin : g_shift
      assign min_out = OUT_W'(minor_accumulator) << (OUT_FRAC_BITS - SLOPE_FRAC_BITS);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (op)
        OP_TAKE: begin
          if (emit && last) begin
            line_active <= 1'b0;
          end
        end
        OP_SETUP: begin
          line_active <= 1'b0;
        end
        OP_DIV: begin
        end
        OP_FINISH: begin
          line_active <= 1'b1;
        end
        default: begin
        end
      endcase
    end

    case (op)
      OP_TAKE: begin
        if (status.start_taken) begin
          ax <= s_tdata[COORD_BITS-1:0];
          ay <= s_tdata[2*COORD_BITS-1:COORD_BITS];
          bx <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
          by <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
        end
        if (emit) begin
          m_tdata <= OUT_DATA_W'({mx_out_y(major_is_x, maj_out, min_out),
                                  major_is_x ? maj_out : min_out});
          m_tlast <= last;
          if (!last) begin
            current_major     <= step_backward ? current_major - COORD_BITS'(1)
                                               : current_major + COORD_BITS'(1);
            minor_accumulator <= minor_accumulator +
                                 {{(ACC_W - SLOPE_W){slope_value[SLOPE_W-1]}}, slope_value};
          end
        end
      end
      OP_SETUP: begin
        major_is_x        <= mx;
        step_backward     <= mx ? dx[COORD_BITS] : dy[COORD_BITS];
        minor_neg         <= mx ? dy[COORD_BITS] : dx[COORD_BITS];
        current_major     <= mx ? ax : ay;
        final_major       <= mx ? bx : by;
        minor_accumulator <= ACC_W'(minor_start) << SLOPE_FRAC_BITS;
        divisor           <= admaj;
        cnt               <= CNT_W'(SLOPE_FRAC_BITS);
        if (admin >= admaj) begin
          quo <= QUO_W'(1);
          rem <= admin - admaj;
        end else begin
          quo <= '0;
          rem <= admin;
        end
      end
      OP_DIV: begin
        rem <= rem_ge ? COORD_BITS'(rem_shift - {1'b0, divisor}) : rem_shift[COORD_BITS-1:0];
        quo <= {quo[QUO_W-2:0], rem_ge};
        cnt <= cnt - CNT_W'(1);
      end
      OP_FINISH: begin
        slope_value <= minor_neg ? SLOPE_W'(0) - SLOPE_W'(quo) : SLOPE_W'(quo);
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/slope_line_rasterizer.sv]
`timescale 1ns / 1ps

// channel   dir  fields
// s_*       in   tuser: command (0 start, 1 step); tdata: first_x, first_y, second_x, second_y
// m_*       out  tdata: point_x, point_y (Q12.8); tlast: last_point
//
// a step word is taken every cycle while the output drains: one point per cycle on a live line
// a start word holds the sequencer after acceptance: setup, 16 restoring divide steps for
// the slope, finish; identical endpoints release it after setup alone
// rst is synchronous: sequencer back to its first step, no active line, output empty
// a stalled output keeps its word; input is held off until the output register frees

module slope_line_rasterizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic                            s_tuser,  // command
  input  logic [slr_pkg::IN_DATA_W-1:0]   s_tdata,  // first_x, first_y, second_x, second_y
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [slr_pkg::OUT_DATA_W-1:0]  m_tdata,  // point_x, point_y
  output logic                            m_tlast
);
  import slr_pkg::*;

  uword_t     uw;
  dp_status_t status;

  slr_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uw     (uw)
  );

  slr_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .op       (uw.op),
    .status   (status),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[hdl/slr_checker.sv]
`timescale 1ns / 1ps

module slr_port_checks (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [slr_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                            m_tlast
);
  import slr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_START) |=> !s_tready)
    else $error("input taken during slope setup");

  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == CMD_STEP)))
    else $error("point without an accepted step word");

endmodule

bind slope_line_rasterizer slr_port_checks u_slr_checker (.*);

[tb/sv/slr_checker.sv]
`timescale 1ns / 1ps

module slr_checker
  import slr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic                  s_tuser,  // command
  input  logic [IN_DATA_W-1:0]  s_tdata,  // first_x, first_y, second_x, second_y
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,  // point_x, point_y
  input  logic                  m_tlast,
  output int                    mismatch_count,
  output int                    points_due
);

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic             last;
  } point_t;

  localparam int UP_SH  = (OUT_FRAC_BITS >= SLOPE_FRAC_BITS) ?
                          OUT_FRAC_BITS - SLOPE_FRAC_BITS : 0;
  localparam int RND_SH = (SLOPE_FRAC_BITS > OUT_FRAC_BITS) ?
                          SLOPE_FRAC_BITS - OUT_FRAC_BITS : 1;
  localparam logic [63:0] OUT_MAX = (64'd1 << OUT_W) - 64'd1;

  point_t point_q[$];

  logic                      line_on   = 1'b0;
  logic                      major_x   = 1'b0;
  logic                      backward  = 1'b0;
  logic [COORD_BITS-1:0]     cur_major = '0;
  logic [COORD_BITS-1:0]     end_major = '0;
  logic [ACC_W-1:0]          minor_acc = '0;
  logic signed [SLOPE_W-1:0] slope     = '0;

  // minor accumulator down to output precision, round half up, saturate
  function automatic logic [OUT_W-1:0] minor_fixed(input logic [ACC_W-1:0] acc);
    logic [63:0] v;
    if (OUT_FRAC_BITS >= SLOPE_FRAC_BITS) begin
      v = 64'(acc) << UP_SH;
    end else begin
      v = (64'(acc) + (64'd1 << (RND_SH - 1))) >> RND_SH;
    end
    if (v > OUT_MAX) begin
      v = OUT_MAX;
    end
    return v[OUT_W-1:0];
  endfunction

  task automatic trace_word(input logic cmd, input logic [IN_DATA_W-1:0] data);
    int ax, ay, bx, by, dx, dy, adx, ady, dmin, admaj, admin;
    logic [63:0] mag;
    logic [OUT_W-1:0] maj, mn;
    point_t p;
    ax = int'(data[COORD_BITS-1:0]);
    ay = int'(data[2*COORD_BITS-1:COORD_BITS]);
    bx = int'(data[3*COORD_BITS-1:2*COORD_BITS]);
    by = int'(data[4*COORD_BITS-1:3*COORD_BITS]);
    if (cmd == CMD_START) begin
      dx  = bx - ax;
      dy  = by - ay;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      if (dx == 0 && dy == 0) begin
        line_on = 1'b0;
      end else begin
        major_x = (adx >= ady);
        if (major_x) begin
          backward  = (dx < 0);
          dmin      = dy;
          admaj     = adx;
          admin     = ady;
          cur_major = COORD_BITS'(ax);
          end_major = COORD_BITS'(bx);
          minor_acc = ACC_W'(ay) << SLOPE_FRAC_BITS;
        end else begin
          backward  = (dy < 0);
          dmin      = dx;
          admaj     = ady;
          admin     = adx;
          cur_major = COORD_BITS'(ay);
          end_major = COORD_BITS'(by);
          minor_acc = ACC_W'(ax) << SLOPE_FRAC_BITS;
        end
        mag     = (64'(admin) << SLOPE_FRAC_BITS) / 64'(admaj);
        slope   = (dmin < 0) ? -SLOPE_W'(mag) : SLOPE_W'(mag);
        line_on = 1'b1;
      end
    end else if (line_on) begin
      maj    = OUT_W'(cur_major) << OUT_FRAC_BITS;
      mn     = minor_fixed(minor_acc);
      p.x    = major_x ? maj : mn;
      p.y    = major_x ? mn : maj;
      p.last = (cur_major == end_major);
      point_q.push_back(p);
      if (p.last) begin
        line_on = 1'b0;
      end else begin
        cur_major = backward ? cur_major - 1'b1 : cur_major + 1'b1;
        minor_acc = minor_acc + {{(ACC_W-SLOPE_W){slope[SLOPE_W-1]}}, slope};
      end
    end
  endtask

  task automatic check_field(input string what, input logic [OUT_W-1:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      line_on   = 1'b0;
      major_x   = 1'b0;
      backward  = 1'b0;
      cur_major = '0;
      end_major = '0;
      minor_acc = '0;
      slope     = '0;
      mismatch_count = 0;
      point_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (point_q.size() == 0) begin
          $display("%0t: no point expected, got x=%h y=%h last=%b", $time,
                   m_tdata[OUT_W-1:0], m_tdata[2*OUT_W-1:OUT_W], m_tlast);
          mismatch_count++;
        end else begin
          want = point_q.pop_front();
          check_field("point_x", want.x, m_tdata[OUT_W-1:0]);
          check_field("point_y", want.y, m_tdata[2*OUT_W-1:OUT_W]);
          check_field("last_point", OUT_W'(want.last), OUT_W'(m_tlast));
        end
      end
      if (s_tvalid && s_tready) begin
        trace_word(s_tuser, s_tdata);
      end
    end
    points_due <= point_q.size();
  end

endmodule

[tb/sv/tb_slope_line_rasterizer.sv]
`timescale 1ns / 1ps

module tb_slope_line_rasterizer;
  import slr_pkg::*;

  localparam int WORD_COUNT  = 650;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_COORD   = (1 << COORD_BITS) - 1;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic                  s_tuser  = CMD_STEP;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  int   tx_idle     = 0;
  int   rx_idle     = 0;
  int   words_sent  = 0;
  int   quiet_cycles = 0;
  logic hold_req    = 1'b0;
  logic hold_ack    = 1'b0;
  int   hold_left   = 0;
  int   mismatch_count;
  int   points_due;

  slope_line_rasterizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  slr_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tuser        (s_tuser),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .points_due     (points_due)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // output side: random stalls, plus one long hold when requested
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_word(input logic cmd, input logic [COORD_BITS-1:0] fx, fy, sx, sy);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= IN_DATA_W'({sy, sx, fy, fx});
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic put_step();
    put_word(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
             COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  task automatic draw_line(input int fx, fy, sx, sy, steps);
    put_word(CMD_START, COORD_BITS'(fx), COORD_BITS'(fy), COORD_BITS'(sx), COORD_BITS'(sy));
    repeat (steps) put_step();
  endtask

  function automatic int pick_near(input int c, input int span);
    int lo, hi;
    lo = (c > span) ? c - span : 0;
    hi = (c + span < MAX_COORD) ? c + span : MAX_COORD;
    return $urandom_range(lo, hi);
  endfunction

  task automatic random_line();
    int fx, fy, sx, sy, r, adx, ady, len, steps;
    r  = $urandom_range(0, 99);
    fx = $urandom_range(0, MAX_COORD);
    fy = $urandom_range(0, MAX_COORD);
    if (r < 8) begin
      put_step();
      return;
    end
    if (r < 12) begin
      sx = fx;
      sy = fy;
    end else if (r < 25) begin
      sx = $urandom_range(0, MAX_COORD);
      sy = $urandom_range(0, MAX_COORD);
    end else begin
      sx = pick_near(fx, (r < 90) ? 12 : 60);
      sy = pick_near(fy, (r < 90) ? 12 : 60);
    end
    adx = (sx > fx) ? sx - fx : fx - sx;
    ady = (sy > fy) ? sy - fy : fy - sy;
    len = ((adx > ady) ? adx : ady) + 1;
    if (len > 64) begin
      steps = $urandom_range(1, 24);
    end else if ($urandom_range(0, 9) == 0) begin
      steps = $urandom_range(0, len);
    end else begin
      steps = len + $urandom_range(0, 2);
    end
    draw_line(fx, fy, sx, sy, steps);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // step with no line, then a zero-length line
    put_step();
    draw_line(5, 5, 5, 5, 1);
    // short line, one step past the end
    draw_line(0, 0, 3, 1, 5);
    // backward on both axes at the top corner
    draw_line(MAX_COORD, MAX_COORD, MAX_COORD - 3, MAX_COORD - 2, 4);
    // vertical, backward
    draw_line(0, MAX_COORD, 0, MAX_COORD - 2, 3);
    // full diagonal dropped by the next start
    draw_line(0, 0, MAX_COORD, MAX_COORD, 2);
    draw_line(MAX_COORD - 2, 0, MAX_COORD, 2, 3);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 21 : (ph == 1) ? 73 : 0;
      rx_idle <= (ph == 0) ? 73 : (ph == 1) ? 21 : 0;
      if (ph == 2) begin
        // long output hold while the sender keeps pushing steps
        hold_req <= ~hold_req;
        draw_line(100, 200, 179, 230, 80);
      end
      while (words_sent < WORD_COUNT * (ph + 1) / 3) random_line();
      s_tvalid <= 1'b0;
      @(posedge clk);
      while (points_due != 0) @(posedge clk);
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && points_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
